// ===== design/rrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared constants, codes and types of the round-robin burst scheduler.
// ----------------------------------------------------------------------------
package rrbs_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int BURST_W  = 8;
  localparam int Q_W      = 8;
  localparam int TIME_W   = 16;
  localparam int SUM_W    = 20;
  localparam int CMD_W    = 2;

  localparam logic [Q_W-1:0] QUANTUM_RST = Q_W'(4);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  typedef enum logic [1:0] {
    KIND_SLICE     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_LOAD_OK   = 2'd2,
    KIND_LOAD_FULL = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic exec;
  } rrbs_cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   job_index;
    logic [TIME_W-1:0]  slice_start;
    logic [TIME_W-1:0]  slice_end;
    logic               job_finished;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [SUM_W-1:0]   total_turnaround;
    logic [SUM_W-1:0]   total_waiting;
    logic [CNT_W-1:0]   job_count;
  } rrbs_res_t;

endpackage

// ===== design/rrbs_if.sv =====
// ----------------------------------------------------------------------------
// rrbs_if
// Valid/ready channels of the scheduler: command input, result output and
// quantum configuration write.
// ----------------------------------------------------------------------------
interface rrbs_in_if import rrbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [BURST_W-1:0] burst_time;

  modport source (output valid, output command, output burst_time, input ready);
  modport sink (input valid, input command, input burst_time, output ready);
endinterface

interface rrbs_out_if import rrbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [IDX_W-1:0]  job_index;
  logic [TIME_W-1:0] slice_start;
  logic [TIME_W-1:0] slice_end;
  logic              job_finished;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [SUM_W-1:0]  total_turnaround;
  logic [SUM_W-1:0]  total_waiting;
  logic [CNT_W-1:0]  job_count;

  modport source (
    output valid, output kind, output job_index, output slice_start, output slice_end,
    output job_finished, output turnaround, output waiting, output total_turnaround,
    output total_waiting, output job_count, input ready
  );
  modport sink (
    input valid, input kind, input job_index, input slice_start, input slice_end,
    input job_finished, input turnaround, input waiting, input total_turnaround,
    input total_waiting, input job_count, output ready
  );
endinterface

interface rrbs_cfg_if import rrbs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] quantum;

  modport source (output valid, output quantum, input ready);
  modport sink (input valid, input quantum, output ready);
endinterface

// ===== design/rrbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Controller: takes commands, sequences load/step execution and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module rrbs_ctrl import rrbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rrbs_cmd_t        cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   needs_exec;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (in_command) inside
      CMD_LOAD, CMD_STEP: needs_exec = 1'b1;
      default:            needs_exec = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && needs_exec) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        cmd.clear   = in_valid && (in_command == CMD_CLEAR);
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/rrbs_dp.sv =====
// ----------------------------------------------------------------------------
// rrbs_dp
// Datapath: job tables, pending scan, clock and totals, result register.
// ----------------------------------------------------------------------------
module rrbs_dp import rrbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rrbs_cmd_t          cmd,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [BURST_W-1:0] in_burst,
  input  logic               cfg_we,
  input  logic [Q_W-1:0]     cfg_quantum,
  output rrbs_res_t          res
);

  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [BURST_W-1:0] rem_mem   [MAX_JOBS];

  logic [Q_W-1:0]      quantum_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    nptr_r, nptr_nxt;
  logic [TIME_W-1:0]   clk_r, clk_nxt;
  logic [SUM_W-1:0]    sum_tat_r, sum_tat_nxt;
  logic [SUM_W-1:0]    sum_wt_r, sum_wt_nxt;
  logic [MAX_JOBS-1:0] pend_r, pend_nxt;

  logic [CMD_W-1:0]    op_r;
  logic [BURST_W-1:0]  burst_in_r;
  logic [IDX_W-1:0]    idx_r;
  logic                found_r;
  logic [BURST_W-1:0]  rd_rem_r;
  logic [BURST_W-1:0]  rd_burst_r;
  rrbs_res_t           res_r, res_nxt;

  logic               scan_found;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   scan_pos;

  logic [Q_W-1:0]     q_eff;
  logic [BURST_W-1:0] run;
  logic [BURST_W-1:0] rem_new;
  logic [TIME_W:0]    clk_sum;
  logic [TIME_W-1:0]  clk_new;
  logic [TIME_W-1:0]  wt;
  logic [SUM_W:0]     tat_acc;
  logic [SUM_W:0]     wt_acc;
  logic [SUM_W-1:0]   tat_sat;
  logic [SUM_W-1:0]   wt_sat;
  logic [IDX_W-1:0]   nptr_step;
  logic               load_ok;
  logic [IDX_W-1:0]   load_slot;

  logic               burst_we;
  logic               rem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [BURST_W-1:0] wr_rem;

  // first pending job at or after the pointer, cyclic
  always_comb begin
    scan_found = 1'b0;
    scan_idx   = '0;
    scan_pos   = '0;
    for (int k = MAX_JOBS - 1; k >= 0; k--) begin
      scan_pos = nptr_r + IDX_W'(k);
      if (pend_r[scan_pos]) begin
        scan_found = 1'b1;
        scan_idx   = scan_pos;
      end
    end
  end

  // slice arithmetic
  always_comb begin
    q_eff     = (quantum_r == '0) ? Q_W'(1) : quantum_r;
    run       = (rd_rem_r < q_eff) ? rd_rem_r : q_eff;
    rem_new   = rd_rem_r - run;
    clk_sum   = {1'b0, clk_r} + (TIME_W + 1)'(run);
    clk_new   = clk_sum[TIME_W] ? '1 : clk_sum[TIME_W-1:0];
    wt        = (clk_new > TIME_W'(rd_burst_r)) ? clk_new - TIME_W'(rd_burst_r) : '0;
    tat_acc   = {1'b0, sum_tat_r} + (SUM_W + 1)'(clk_new);
    wt_acc    = {1'b0, sum_wt_r} + (SUM_W + 1)'(wt);
    tat_sat   = tat_acc[SUM_W] ? '1 : tat_acc[SUM_W-1:0];
    wt_sat    = wt_acc[SUM_W] ? '1 : wt_acc[SUM_W-1:0];
    nptr_step = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r) ? '0 : idx_r + IDX_W'(1);
    load_ok   = cnt_r < CNT_W'(MAX_JOBS);
    load_slot = cnt_r[IDX_W-1:0];
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    nptr_nxt    = nptr_r;
    clk_nxt     = clk_r;
    sum_tat_nxt = sum_tat_r;
    sum_wt_nxt  = sum_wt_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    burst_we    = 1'b0;
    rem_we      = 1'b0;
    wr_addr     = idx_r;
    wr_rem      = rem_new;
    if (cmd.clear) begin
      cnt_nxt     = '0;
      nptr_nxt    = '0;
      clk_nxt     = '0;
      sum_tat_nxt = '0;
      sum_wt_nxt  = '0;
      pend_nxt    = '0;
    end else if (cmd.exec) begin
      res_nxt = '0;
      if (op_r == CMD_LOAD) begin
        if (load_ok) begin
          burst_we            = 1'b1;
          rem_we              = 1'b1;
          wr_addr             = load_slot;
          wr_rem              = burst_in_r;
          pend_nxt[load_slot] = (burst_in_r != '0);
          cnt_nxt             = cnt_r + CNT_W'(1);
          res_nxt.kind        = KIND_LOAD_OK;
          res_nxt.job_index   = load_slot;
        end else begin
          res_nxt.kind = KIND_LOAD_FULL;
        end
      end else if (!found_r) begin
        res_nxt.kind = KIND_DONE;
      end else begin
        rem_we              = 1'b1;
        clk_nxt             = clk_new;
        nptr_nxt            = nptr_step;
        res_nxt.kind        = KIND_SLICE;
        res_nxt.job_index   = idx_r;
        res_nxt.slice_start = clk_r;
        res_nxt.slice_end   = clk_new;
        if (rem_new == '0) begin
          pend_nxt[idx_r]      = 1'b0;
          sum_tat_nxt          = tat_sat;
          sum_wt_nxt           = wt_sat;
          res_nxt.job_finished = 1'b1;
          res_nxt.turnaround   = clk_new;
          res_nxt.waiting      = wt;
        end
      end
      res_nxt.total_turnaround = sum_tat_nxt;
      res_nxt.total_waiting    = sum_wt_nxt;
      res_nxt.job_count        = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
      cnt_r     <= '0;
      nptr_r    <= '0;
      clk_r     <= '0;
      sum_tat_r <= '0;
      sum_wt_r  <= '0;
      pend_r    <= '0;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_quantum;
      end
      cnt_r     <= cnt_nxt;
      nptr_r    <= nptr_nxt;
      clk_r     <= clk_nxt;
      sum_tat_r <= sum_tat_nxt;
      sum_wt_r  <= sum_wt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_command;
      burst_in_r <= in_burst;
      idx_r      <= scan_idx;
      found_r    <= scan_found;
    end
    res_r <= res_nxt;
  end

  // job tables
  always_ff @(posedge clk) begin
    if (burst_we) begin
      burst_mem[wr_addr] <= burst_in_r;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (cmd.capture) begin
      rd_rem_r   <= rem_mem[scan_idx];
      rd_burst_r <= burst_mem[scan_idx];
    end
  end

  assign res = res_r;

endmodule

// ===== design/round_robin_burst_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_burst_scheduler
// Round-robin job scheduler with a configurable time quantum: loads job bursts,
// issues at most one time slice per step and tracks turnaround and waiting totals.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        command, burst_time
//   out_ch   out  valid/ready        kind .. job_count (one result per load or step)
//   cfg_ch   in   valid/ready        quantum
//
// load and step are accepted first (pending scan, table read registered),
// then executed once the output register is free
// clear and the unused command code are taken while idle and give no result
// in_ch.ready is high while idle, also while a result waits in out_ch
// cfg_ch.ready is always high; reset is synchronous, no clearing pass
// ----------------------------------------------------------------------------
module round_robin_burst_scheduler import rrbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rrbs_in_if.sink    in_ch,
  rrbs_out_if.source out_ch,
  rrbs_cfg_if.sink   cfg_ch
);

  rrbs_cmd_t cmd;
  rrbs_res_t res;

  rrbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  rrbs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_command  (in_ch.command),
    .in_burst    (in_ch.burst_time),
    .cfg_we      (cfg_ch.valid),
    .cfg_quantum (cfg_ch.quantum),
    .res         (res)
  );

  assign cfg_ch.ready            = 1'b1;
  assign out_ch.kind             = res.kind;
  assign out_ch.job_index        = res.job_index;
  assign out_ch.slice_start      = res.slice_start;
  assign out_ch.slice_end        = res.slice_end;
  assign out_ch.job_finished     = res.job_finished;
  assign out_ch.turnaround       = res.turnaround;
  assign out_ch.waiting          = res.waiting;
  assign out_ch.total_turnaround = res.total_turnaround;
  assign out_ch.total_waiting    = res.total_waiting;
  assign out_ch.job_count        = res.job_count;

endmodule

// ===== design/rrbs_checker.sv =====
// ----------------------------------------------------------------------------
// rrbs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrbs_checker import rrbs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [TIME_W-1:0] out_slice_end,
  input logic              out_job_finished,
  input logic [TIME_W-1:0] out_turnaround,
  input logic [CNT_W-1:0]  out_job_count
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // load or step transfer blocks input while in the execute state
  a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD || in_command == CMD_STEP)
    |=> !in_ready)
    else $error("input taken during execute");

  // rejected load only with a full table
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_LOAD_FULL |-> out_job_count == CNT_W'(MAX_JOBS))
    else $error("load rejected below capacity");

  // finished job ends on its slice end
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_job_finished |->
    out_kind == KIND_SLICE && out_turnaround == out_slice_end)
    else $error("inconsistent job completion");

endmodule

bind round_robin_burst_scheduler rrbs_checker u_rrbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_command       (in_ch.command),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_slice_end    (out_ch.slice_end),
  .out_job_finished (out_ch.job_finished),
  .out_turnaround   (out_ch.turnaround),
  .out_job_count    (out_ch.job_count)
);
